FILE: design/bresenham_line_rasterizer_defines.svh
// assertion helpers for the line rasterizer
`ifndef BRESENHAM_LINE_RASTERIZER_DEFINES_SVH
`define BRESENHAM_LINE_RASTERIZER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BLR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define BLR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/blr_pkg.sv
package blr_pkg;

  localparam int COORD_W = 16;
  localparam int COLOR_W = 24;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [COLOR_W-1:0]        color_t;

  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_ADVANCE = 1'b1
  } cmd_e;

  typedef struct packed {
    coord_t x;
    coord_t y;
    color_t color;
    logic   last;
  } pixel_t;

endpackage

FILE: design/bresenham_line_rasterizer.sv
// Bresenham line rasterizer, all octants.
// Input channel (in_valid / in_stall): a load command (in_command = load) takes the two
// endpoints and the color and gives no pixel; an advance command gives the next pixel
// of the current line. The last pixel of a line carries out_last_pixel; the far endpoint
// is not drawn, and a zero-length line gives no pixels. An advance while idle is taken
// and dropped. A load while a line is running replaces that line.
// Output channel (out_valid / out_stall): one pixel per advance, in command order.
// Throughput: one command per cycle while in_stall is low; each pixel is registered
// into an output register, and the error update is one add and compare per pixel.
// A second output register absorbs one pixel while the receiver stalls, so the input
// keeps taking transfers until both output registers hold pixels; in_stall is then
// raised from a register and drops again once the receiver takes a pixel.
// Reset (synchronous, active low) empties both output registers and leaves the block idle.
// COORD_BITS sets the coordinate width used inside; higher input bits are ignored and
// output coordinates are sign extended to the port width.
`include "bresenham_line_rasterizer_defines.svh"

module bresenham_line_rasterizer #(
  parameter int COORD_BITS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  blr_pkg::cmd_e   in_command,
  input  blr_pkg::coord_t in_x_start,
  input  blr_pkg::coord_t in_y_start,
  input  blr_pkg::coord_t in_x_end,
  input  blr_pkg::coord_t in_y_end,
  input  blr_pkg::color_t in_color,
  output logic            out_valid,
  input  logic            out_stall,
  output blr_pkg::coord_t out_pixel_x,
  output blr_pkg::coord_t out_pixel_y,
  output blr_pkg::color_t out_pixel_color,
  output logic            out_last_pixel
);
  import blr_pkg::*;

  localparam int C = COORD_BITS;
  localparam int D = COORD_BITS + 1;
  localparam int E = COORD_BITS + 3;

  // line state
  logic                busy_r, busy_nxt;
  logic                x_major_r, x_major_nxt;
  logic signed [C-1:0] cur_x_r, cur_x_nxt;
  logic signed [C-1:0] cur_y_r, cur_y_nxt;
  logic signed [C-1:0] major_stop_r, major_stop_nxt;
  logic                minor_down_r, minor_down_nxt;
  logic signed [E-1:0] err_r, err_nxt;
  logic [C:0]          tm_r, tm_nxt;
  logic signed [C+1:0] tmlm_r, tmlm_nxt;
  color_t              color_r, color_nxt;

  // output registers
  logic   out_valid_r, out_valid_nxt;
  logic   skid_valid_r, skid_valid_nxt;
  pixel_t out_r, out_nxt;
  pixel_t skid_r, skid_nxt;

  logic   in_fire, out_fire, res_v;
  pixel_t res;

  // load decode
  logic signed [C-1:0] xa, ya, xb, yb;
  logic signed [D-1:0] dx, dy;
  logic [C-1:0]        adx, ady, amaj, amin;
  logic                x_major_ld, swap_ld, minor_down_ld;
  logic signed [E-1:0] amaj_e, amin_e;

  // advance
  logic signed [C-1:0] cur_major, cur_minor, minor_nxt;
  logic                last, step_minor;

  assign in_fire  = in_valid & ~in_stall;
  assign out_fire = out_valid_r & ~out_stall;
  assign in_stall = skid_valid_r;

  assign xa = in_x_start[C-1:0];
  assign ya = in_y_start[C-1:0];
  assign xb = in_x_end[C-1:0];
  assign yb = in_y_end[C-1:0];

  always_comb begin
    dx  = D'(xb) - D'(xa);
    dy  = D'(yb) - D'(ya);
    adx = dx[D-1] ? C'(-dx) : C'(dx);
    ady = dy[D-1] ? C'(-dy) : C'(dy);
    x_major_ld = adx > ady;
    if (x_major_ld) begin
      swap_ld       = dx[D-1];
      minor_down_ld = dx[D-1] ? (!dy[D-1] && (dy != '0)) : dy[D-1];
      amaj          = adx;
      amin          = ady;
    end else begin
      swap_ld       = dy[D-1];
      minor_down_ld = dy[D-1] ? (!dx[D-1] && (dx != '0)) : dx[D-1];
      amaj          = ady;
      amin          = adx;
    end
    amaj_e = E'(amaj);
    amin_e = E'(amin);
  end

  always_comb begin
    cur_major  = x_major_r ? cur_x_r : cur_y_r;
    cur_minor  = x_major_r ? cur_y_r : cur_x_r;
    last       = C'(cur_major + C'(1)) == major_stop_r;
    step_minor = err_r > 0;
    if (!step_minor) begin
      minor_nxt = cur_minor;
    end else if (minor_down_r) begin
      minor_nxt = C'(cur_minor - C'(1));
    end else begin
      minor_nxt = C'(cur_minor + C'(1));
    end
  end

  assign res_v     = in_fire && (in_command == CMD_ADVANCE) && busy_r;
  assign res.x     = COORD_W'(cur_x_r);
  assign res.y     = COORD_W'(cur_y_r);
  assign res.color = color_r;
  assign res.last  = last;

  always_comb begin
    busy_nxt       = busy_r;
    x_major_nxt    = x_major_r;
    cur_x_nxt      = cur_x_r;
    cur_y_nxt      = cur_y_r;
    major_stop_nxt = major_stop_r;
    minor_down_nxt = minor_down_r;
    err_nxt        = err_r;
    tm_nxt         = tm_r;
    tmlm_nxt       = tmlm_r;
    color_nxt      = color_r;
    if (in_fire && (in_command == CMD_LOAD)) begin
      color_nxt      = in_color;
      x_major_nxt    = x_major_ld;
      minor_down_nxt = minor_down_ld;
      cur_x_nxt      = swap_ld ? xb : xa;
      cur_y_nxt      = swap_ld ? yb : ya;
      if (x_major_ld) begin
        major_stop_nxt = swap_ld ? xa : xb;
      end else begin
        major_stop_nxt = swap_ld ? ya : yb;
      end
      tm_nxt   = {amin, 1'b0};
      tmlm_nxt = (C+2)'((amin_e - amaj_e) <<< 1);
      err_nxt  = (amin_e <<< 1) - amaj_e;
      busy_nxt = amaj != '0;
    end else if (res_v) begin
      if (x_major_r) begin
        cur_x_nxt = C'(cur_x_r + C'(1));
        cur_y_nxt = minor_nxt;
      end else begin
        cur_y_nxt = C'(cur_y_r + C'(1));
        cur_x_nxt = minor_nxt;
      end
      err_nxt  = step_minor ? (err_r + E'(tmlm_r)) : (err_r + E'(tm_r));
      busy_nxt = !last;
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (out_fire || !out_valid_r) begin
      out_nxt        = skid_valid_r ? skid_r : res;
      out_valid_nxt  = skid_valid_r | res_v;
      skid_valid_nxt = 1'b0;
    end else if (res_v) begin
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      x_major_r    <= 1'b0;
      cur_x_r      <= '0;
      cur_y_r      <= '0;
      major_stop_r <= '0;
      minor_down_r <= 1'b0;
      err_r        <= '0;
      tm_r         <= '0;
      tmlm_r       <= '0;
      color_r      <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      busy_r       <= busy_nxt;
      x_major_r    <= x_major_nxt;
      cur_x_r      <= cur_x_nxt;
      cur_y_r      <= cur_y_nxt;
      major_stop_r <= major_stop_nxt;
      minor_down_r <= minor_down_nxt;
      err_r        <= err_nxt;
      tm_r         <= tm_nxt;
      tmlm_r       <= tmlm_nxt;
      color_r      <= color_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = out_r.x;
  assign out_pixel_y     = out_r.y;
  assign out_pixel_color = out_r.color;
  assign out_last_pixel  = out_r.last;

  `BLR_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r, "skid full with empty output")
  `BLR_ASSERT_NOW(a_major_below_stop, busy_r, cur_major < major_stop_r, "major passed its stop")
  `BLR_ASSERT_NEXT(a_last_ends_line, res_v && last, !busy_r, "line still busy after last pixel")
  `BLR_ASSERT_NEXT(a_skid_refills_out, out_fire && skid_valid_r, out_valid_r, "skid pixel lost")

endmodule

FILE: test/bresenham_line_rasterizer_tb.sv
`timescale 1ns / 1ps

module bresenham_line_rasterizer_tb;
  import blr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned RANDOM_ITEMS = 1500;
  localparam int unsigned DRAIN_CYCLES = 8;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_stall;
  cmd_e   in_command = CMD_LOAD;
  coord_t in_x_start = '0;
  coord_t in_y_start = '0;
  coord_t in_x_end = '0;
  coord_t in_y_end = '0;
  color_t in_color = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  coord_t out_pixel_x;
  coord_t out_pixel_y;
  color_t out_pixel_color;
  logic   out_last_pixel;

  bresenham_line_rasterizer dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_x_start     (in_x_start),
    .in_y_start     (in_y_start),
    .in_x_end       (in_x_end),
    .in_y_end       (in_y_end),
    .in_color       (in_color),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_pixel_color(out_pixel_color),
    .out_last_pixel (out_last_pixel)
  );

  // line walker state
  logic   line_busy = 1'b0;
  logic   along_x = 1'b0;
  longint pos_x = 0;
  longint pos_y = 0;
  longint stop_at = 0;
  logic   step_down = 1'b0;
  longint err_acc = 0;
  longint inc_flat = 0;
  longint inc_diag = 0;
  color_t job_color = '0;

  pixel_t      pending_pixels[$];
  int unsigned useful_transfers = 0;
  int unsigned line_loads = 0;
  int unsigned pixels_checked = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned tx_burst = 0;
  int unsigned rx_burst = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic longint span(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int unsigned idle_len(inout int unsigned burst_left);
    int unsigned r;
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      burst_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic coord_t clip_coord(longint v);
    if (v > 32767) return coord_t'(32767);
    if (v < -32768) return coord_t'(-32768);
    return coord_t'(v);
  endfunction

  function automatic void rasterize_transfer(cmd_e c, coord_t xs, coord_t ys, coord_t xe,
                                             coord_t ye, color_t col);
    longint xa, ya, xb, yb, dmaj, dmin, t;
    pixel_t pix;
    logic   finishing;
    if (c == CMD_LOAD) begin
      xa = xs;
      ya = ys;
      xb = xe;
      yb = ye;
      job_color = col;
      along_x = span(xb - xa) > span(yb - ya);
      if (along_x ? (xa > xb) : (ya > yb)) begin
        t = xa; xa = xb; xb = t;
        t = ya; ya = yb; yb = t;
      end
      dmaj = along_x ? xb - xa : yb - ya;
      dmin = along_x ? yb - ya : xb - xa;
      stop_at = along_x ? xb : yb;
      step_down = dmin < 0;
      dmin = span(dmin);
      pos_x = xa;
      pos_y = ya;
      inc_flat = 2 * dmin;
      inc_diag = 2 * (dmin - dmaj);
      err_acc = 2 * dmin - dmaj;
      line_busy = dmaj > 0;
      line_loads++;
      useful_transfers++;
    end else if (line_busy) begin
      pix.x = pos_x[15:0];
      pix.y = pos_y[15:0];
      pix.color = job_color;
      finishing = ((along_x ? pos_x : pos_y) + 1) == stop_at;
      pix.last = finishing;
      if (err_acc > 0) begin
        if (along_x) pos_y += step_down ? -1 : 1;
        else pos_x += step_down ? -1 : 1;
        err_acc += inc_diag;
      end else begin
        err_acc += inc_flat;
      end
      if (along_x) pos_x += 1;
      else pos_y += 1;
      if (finishing) line_busy = 1'b0;
      pending_pixels.push_back(pix);
      useful_transfers++;
    end
  endfunction

  task automatic send_cmd(cmd_e c, coord_t xs, coord_t ys, coord_t xe, coord_t ye,
                          color_t col);
    int unsigned gap;
    gap = idle_len(tx_burst);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= c;
    in_x_start <= xs;
    in_y_start <= ys;
    in_x_end <= xe;
    in_y_end <= ye;
    in_color <= col;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rasterize_transfer(c, xs, ys, xe, ye, col);
  endtask

  task automatic load_line(coord_t xs, coord_t ys, coord_t xe, coord_t ye, color_t col);
    send_cmd(CMD_LOAD, xs, ys, xe, ye, col);
  endtask

  task automatic advance_pixels(int unsigned n);
    repeat (n) begin
      send_cmd(CMD_ADVANCE, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
               coord_t'($urandom), color_t'($urandom));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected pixel transfer x=%0d y=%0d", out_pixel_x, out_pixel_y);
        mismatch_count++;
      end else begin
        pixel_t want;
        want = pending_pixels.pop_front();
        pixels_checked++;
        if (out_pixel_x !== want.x) begin
          $error("pixel_x: expected %0d, got %0d", want.x, out_pixel_x);
          mismatch_count++;
        end
        if (out_pixel_y !== want.y) begin
          $error("pixel_y: expected %0d, got %0d", want.y, out_pixel_y);
          mismatch_count++;
        end
        if (out_pixel_color !== want.color) begin
          $error("pixel_color: expected %06h, got %06h", want.color, out_pixel_color);
          mismatch_count++;
        end
        if (out_last_pixel !== want.last) begin
          $error("last_pixel: expected %0b, got %0b", want.last, out_last_pixel);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int unsigned n;
    wait (rst_n);
    @(posedge clk);
    forever begin
      n = idle_len(rx_burst);
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
    end
  end

  task automatic test_idle_advance();
    advance_pixels(1);
  endtask

  task automatic test_zero_length();
    load_line(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, 24'h000000);
    advance_pixels(1);
  endtask

  task automatic test_full_range_reload();
    load_line(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 24'hFFFFFF);
    advance_pixels(3);
    load_line(16'sd32767, 16'sd0, 16'sd32764, 16'sd2, 24'h5A5A5A);
    advance_pixels(4);
  endtask

  task automatic test_axis_and_swap();
    load_line(16'sd0, 16'sd5, 16'sd2, 16'sd0, 24'hA5A5A5);
    advance_pixels(5);
    load_line(16'sd5, -16'sd3, 16'sd9, -16'sd3, 24'h123456);
    advance_pixels(4);
    load_line(-16'sd7, 16'sd2, -16'sd7, -16'sd1, 24'hFEDCBA);
    advance_pixels(3);
  endtask

  task automatic test_random_lines();
    int unsigned target, reach, steps, len;
    coord_t      xs, ys, xe, ye;
    logic        wild;
    target = useful_transfers + RANDOM_ITEMS;
    while (useful_transfers < target) begin
      wild = $urandom_range(0, 99) < 10;
      xs = coord_t'($urandom);
      ys = coord_t'($urandom);
      if (wild) begin
        xe = coord_t'($urandom);
        ye = coord_t'($urandom);
      end else begin
        reach = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 12) : $urandom_range(13, 120);
        xe = clip_coord(longint'(xs) + $urandom_range(0, 2 * reach) - reach);
        ye = clip_coord(longint'(ys) + $urandom_range(0, 2 * reach) - reach);
      end
      len = int'(span(longint'(xe) - longint'(xs)) > span(longint'(ye) - longint'(ys)) ?
                 span(longint'(xe) - longint'(xs)) : span(longint'(ye) - longint'(ys)));
      load_line(xs, ys, xe, ye, color_t'($urandom));
      if (wild || $urandom_range(0, 99) < 20) begin
        steps = $urandom_range(0, (len < 30) ? len : 30);
      end else begin
        steps = len;
        if ($urandom_range(0, 99) < 10) steps += $urandom_range(1, 3);
      end
      advance_pixels(steps);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_advance();
    test_zero_length();
    test_full_range_reload();
    test_axis_and_swap();
    test_random_lines();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d useful command transfers over %0d line loads", useful_transfers,
             line_loads);
    $display("checked %0d pixels, %0d mismatches", pixels_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
